// ----- rtl/olv_pkg.sv -----
// Shared types, request and status codes, and the float compare for the ordered value list.
package olv_pkg;

  localparam int VAL_W  = 64;
  localparam int POS_W  = 7;
  localparam int GRP    = 8;

  // request codes
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [POS_W-1:0] POS_NONE = '1;

  localparam logic [VAL_W-1:0] EXP_MASK  = 64'h7FF0_0000_0000_0000;
  localparam logic [VAL_W-1:0] MANT_MASK = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] MAG_MASK  = 64'h7FFF_FFFF_FFFF_FFFF;

  // command broadcast along the row of cells
  typedef struct packed {
    logic             load;
    logic             shift;
    logic             cmp;
    logic [VAL_W-1:0] value;
  } cell_ctrl_t;

  function automatic logic is_nan(input logic [VAL_W-1:0] v);
    return ((v & EXP_MASK) == EXP_MASK) && ((v & MANT_MASK) != '0);
  endfunction

  // floating-point equality: signed zeros match, NaN never does
  function automatic logic fp_equal(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
    logic eq;
    if (is_nan(a) || is_nan(b)) begin
      eq = 1'b0;
    end else if (((a & MAG_MASK) == '0) && ((b & MAG_MASK) == '0)) begin
      eq = 1'b1;
    end else begin
      eq = (a == b);
    end
    return eq;
  endfunction

endpackage

// ----- rtl/olv_cell.sv -----
// One list cell: holds an entry, loads on append, takes its neighbour on delete, compares on request.
module olv_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7,
  parameter int IDX_W = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  olv_pkg::cell_ctrl_t        ctrl_i,
  input  logic [CNT_W-1:0]           count_i,
  input  logic [IDX_W-1:0]           del_idx_i,
  input  logic [olv_pkg::VAL_W-1:0]  next_entry_i,
  output logic [olv_pkg::VAL_W-1:0]  entry_o,
  output logic                       match_o
);
  import olv_pkg::*;

  logic [VAL_W-1:0] entry_q;
  logic             match_q;
  logic             in_list;
  logic             at_tail;
  logic             from_del;

  // place of this cell relative to the list
  assign in_list  = CNT_W'(IDX) < count_i;
  assign at_tail  = CNT_W'(IDX) == count_i;
  assign from_del = IDX_W'(IDX) >= del_idx_i;

  // load at the tail, or close the gap by taking the neighbour
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && at_tail) begin
      entry_q <= ctrl_i.value;
    end else if (ctrl_i.shift && from_del) begin
      entry_q <= next_entry_i;
    end
  end

  // hold the compare result until the next search or delete request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.cmp) begin
      match_q <= in_list && fp_equal(entry_q, ctrl_i.value);
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

// ----- rtl/ordered_value_list.sv -----
// Ordered value list: a row of compare-and-shift cells with a grouped first-match scan.
// Append, unused codes and a search or delete on an empty list go from the taking edge straight
// to S_DONE; search and delete scan the match flags a group of eight at a time in S_SCAN, up to
// the first hit or the last group holding entries, and a delete that hits passes S_SHIFT first.
// A new request is taken from the cycle after the result enters the output register, so no
// request is taken while one is in progress; a result held by the receiver stalls the next.
// Reset empties the list (entry count zero); entry storage is not cleared.
module ordered_value_list #(
  parameter int DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 req_type_i,
  input  logic [olv_pkg::VAL_W-1:0]  item_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic signed [olv_pkg::POS_W-1:0] position_o
);
  import olv_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NGRP  = (DEPTH + GRP - 1) / GRP;
  localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int OFF_W = (GRP > 1) ? $clog2(GRP) : 1;
  localparam int SW    = $clog2(NGRP * GRP + 1) + 1;
  localparam int FW    = (SW > POS_W) ? SW : POS_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;

  logic [2:0]             state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [GRP_W-1:0]       grp_q, grp_d;
  logic [IDX_W-1:0]       del_idx_q, del_idx_d;
  logic                   is_del_q, is_del_d;
  logic [1:0]             res_status_q, res_status_d;
  logic [POS_W-1:0]       res_pos_q, res_pos_d;
  logic                   out_valid_q, out_valid_d;
  logic [1:0]             out_status_q, out_status_d;
  logic [POS_W-1:0]       out_pos_q, out_pos_d;

  cell_ctrl_t             ctrl;
  logic                   accept;
  logic                   full;
  logic [VAL_W-1:0]       entry_w [DEPTH];
  logic [DEPTH-1:0]       match_w;
  logic [NGRP*GRP-1:0]    match_pad;
  logic [GRP-1:0]         grp_bits;
  logic [OFF_W-1:0]       off;
  logic [FW-1:0]          found_w;
  logic [SW-1:0]          next_base;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign full       = (count_q == CNT_W'(DEPTH));

  // broadcast the command to the row
  always_comb begin
    ctrl.value = item_value_i;
    ctrl.load  = accept && (req_type_i == REQ_APPEND) && !full;
    ctrl.cmp   = accept && ((req_type_i == REQ_DELETE) || (req_type_i == REQ_SEARCH));
    ctrl.shift = (state_q == S_SHIFT);
  end

  // row of cells, each from the deleted index up taking its right-hand neighbour on a shift
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] nxt;
    if (i == DEPTH - 1) begin : g_last
      assign nxt = entry_w[i];
    end else begin : g_mid
      assign nxt = entry_w[i+1];
    end
    olv_cell #(
      .IDX   (i),
      .CNT_W (CNT_W),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .del_idx_i    (del_idx_q),
      .next_entry_i (nxt),
      .entry_o      (entry_w[i]),
      .match_o      (match_w[i])
    );
  end

  // pick the current group of match flags and its first set flag
  assign match_pad = (NGRP * GRP)'(match_w);
  assign grp_bits  = match_pad[grp_q*GRP +: GRP];
  assign next_base = SW'((SW'(grp_q) + SW'(1)) * GRP);

  always_comb begin
    off = '0;
    for (int k = GRP - 1; k >= 0; k--) begin
      if (grp_bits[k]) begin
        off = OFF_W'(k);
      end
    end
  end

  assign found_w = FW'(SW'(grp_q) * GRP + SW'(off));

  // request sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    grp_d        = grp_q;
    del_idx_d    = del_idx_q;
    is_del_d     = is_del_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_pos_d    = POS_NONE;
          res_status_d = ST_NOT_FOUND;
          grp_d        = '0;
          is_del_d     = (req_type_i == REQ_DELETE);
          state_d      = S_DONE;
          unique case (req_type_i) inside
            REQ_APPEND: begin
              if (full) begin
                res_status_d = ST_FULL;
              end else begin
                res_status_d = ST_DONE;
                count_d      = count_q + 1'b1;
              end
            end
            REQ_DELETE, REQ_SEARCH: begin
              if (count_q != '0) begin
                state_d = S_SCAN;
              end
            end
            default: begin
              res_status_d = ST_NOT_FOUND;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (grp_bits != '0) begin
          res_status_d = ST_DONE;
          if (is_del_q) begin
            del_idx_d = found_w[IDX_W-1:0];
            state_d   = S_SHIFT;
          end else begin
            res_pos_d = found_w[POS_W-1:0];
            state_d   = S_DONE;
          end
        end else if (next_base >= SW'(count_q)) begin
          state_d = S_DONE;
        end else begin
          grp_d = grp_q + 1'b1;
        end
      end
      S_SHIFT: begin
        count_d = count_q - 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_pos_d    = res_pos_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    grp_q        <= grp_d;
    del_idx_q    <= del_idx_d;
    is_del_q     <= is_del_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign position_o  = out_pos_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i == REQ_APPEND) && !full) |=> (count_q == $past(count_q) + 1'b1))
    else $error("append did not grow the list");

  a_delete_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |=> (count_q == $past(count_q) - 1'b1))
    else $error("delete did not shrink the list");

  a_miss_no_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_DONE)) |-> (out_pos_q == POS_NONE))
    else $error("failed request carries a position");
`endif

endmodule
